[rtl/core/bde_pkg.sv]
package bde_pkg;

  localparam int unsigned BaudW = 27;
  localparam int unsigned ClkW  = 27;
  localparam int unsigned PreW  = 5;
  localparam int unsigned EncW  = 17;
  // clock * 16 fits in 31 bits
  localparam int unsigned ScW   = 31;
  localparam int unsigned DivW  = 18;

  localparam logic [ClkW-1:0] ClockReset    = 27'd48000000;
  localparam logic [PreW-1:0] PrescaleReset = 5'd16;
  localparam logic [DivW-1:0] DivLimit      = 18'h20000;
  localparam logic [DivW-1:0] DivClampVal   = 18'h1ffff;

  localparam logic CfgIdxClock    = 1'b0;
  localparam logic CfgIdxPrescale = 1'b1;

  localparam logic [1:0] CodeFull  = 2'd0;
  localparam logic [1:0] CodeOneHf = 2'd1;
  localparam logic [1:0] CodeTwo   = 2'd2;

  function automatic logic [2:0] frac_remap(input logic [2:0] f);
    logic [2:0] r;
    case (f)
      3'd0: r = 3'd0;
      3'd1: r = 3'd3;
      3'd2: r = 3'd2;
      3'd3: r = 3'd4;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd6;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/bde_divpipe.sv]
// pipelined restoring divider, one quotient bit per stage
module bde_divpipe #(
  parameter int unsigned NumW = 31,
  parameter int unsigned DenW = 27,
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);

  logic [NumW:1]    valid_q;
  logic [NumW-1:0]  num_q [1:NumW];
  logic [DenW:0]    rem_q [1:NumW];
  logic [DenW-1:0]  den_q [1:NumW];
  logic [TagW-1:0]  tag_q [1:NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic            v_in;
    logic [NumW-1:0] num_in;
    logic [DenW:0]   rem_in;
    logic [DenW-1:0] den_in;
    logic [TagW-1:0] tag_in;
    logic [DenW+1:0] trial;
    logic [DenW:0]   rem_d;
    logic [NumW-1:0] num_d;
    if (s == 0) begin : g_head
      assign v_in   = valid_i;
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_body
      assign v_in   = valid_q[s];
      assign num_in = num_q[s];
      assign rem_in = rem_q[s];
      assign den_in = den_q[s];
      assign tag_in = tag_q[s];
    end
    always_comb begin
      trial = {rem_in, num_in[NumW-1]};
      if (trial >= {2'b00, den_in}) begin
        rem_d = (DenW+1)'(trial - {2'b00, den_in});
        num_d = {num_in[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW:0];
        num_d = {num_in[NumW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[s+1] <= num_d;
      rem_q[s+1] <= rem_d;
      den_q[s+1] <= den_in;
      tag_q[s+1] <= tag_in;
    end
  end

  assign valid_o = valid_q[NumW];
  assign quo_o   = num_q[NumW];
  assign tag_o   = tag_q[NumW];

  // final remainder and divisor are not needed
  logic unused;
  assign unused = ^{rem_q[NumW], den_q[NumW]};

endmodule

[rtl/core/baud_divisor_encoder_unit.sv]
// baud divisor encoder
// channels: a request beat enters when start_i is high and busy_o is low;
// busy_o is always low, so a beat may enter every cycle. config writes
// use cfg_we_i / cfg_idx_i / cfg_data_i (index 0 clock_hz, 1 prescale);
// the user must only make them while no request is in flight (unchecked).
// a result beat shows on best_baud_o / encoded_divisor_o for one cycle
// with done_o high; the receiver cannot stall, so none is needed.
// throughput one beat per cycle. the pipeline is three 31-stage
// bit-per-stage dividers in series: clock/threshold (with clock*16/p
// alongside), scaled/baud, scaled/divisor, plus one register after each.
// reset clears all valid bits and loads clock 48 MHz and prescale 16.
module baud_divisor_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [26:0] baud_request_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [26:0] cfg_data_i,
  output logic        done_o,
  output logic [26:0] best_baud_o,
  output logic [16:0] encoded_divisor_o
);

  localparam int unsigned ScW = bde_pkg::ScW;

  logic [bde_pkg::ClkW-1:0] clock_q;
  logic [bde_pkg::PreW-1:0] pre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= bde_pkg::ClockReset;
      pre_q   <= bde_pkg::PrescaleReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bde_pkg::CfgIdxClock) clock_q <= cfg_data_i;
      else pre_q <= cfg_data_i[bde_pkg::PreW-1:0];
    end
  end

  assign busy_o = 1'b0;

  // stage 0: operands, a zero prescale or rate taken as 1; three threshold
  // divides (p, p+p/2, 2p) and the scaled clock all share one clock value
  logic [4:0]  p_eff;
  logic [26:0] baud_eff;
  always_comb begin
    p_eff    = (pre_q == '0) ? 5'd1 : pre_q;
    baud_eff = (baud_request_i == '0) ? 27'd1 : baud_request_i;
  end

  // divider a: thresholds, three lanes sharing a tag
  // lane k den: p, p + p/2, 2p ; num: clock
  logic [26:0] den1, den2, den3;
  assign den1 = {22'd0, p_eff};
  assign den2 = 27'({22'd0, p_eff} + {23'd0, p_eff[4:1]});
  assign den3 = {21'd0, p_eff, 1'b0};

  // the request rides along with the thresholds
  localparam int unsigned TagA = 27;
  logic            va1, va2, va3;
  logic [ScW-1:0]  qa1, qa2, qa3;
  logic [TagA-1:0] ta1, ta2, ta3;

  bde_divpipe #(.NumW(ScW), .DenW(27), .TagW(TagA)) u_thr1 (
    .clk_i, .rst_ni, .valid_i(start_i), .num_i({4'd0, clock_q}), .den_i(den1),
    .tag_i(baud_eff), .valid_o(va1), .quo_o(qa1), .tag_o(ta1));
  bde_divpipe #(.NumW(ScW), .DenW(27), .TagW(TagA)) u_thr2 (
    .clk_i, .rst_ni, .valid_i(start_i), .num_i({4'd0, clock_q}), .den_i(den2),
    .tag_i(baud_eff), .valid_o(va2), .quo_o(qa2), .tag_o(ta2));
  // scaled = clock*16/p computed alongside
  bde_divpipe #(.NumW(ScW), .DenW(27), .TagW(TagA)) u_thr3 (
    .clk_i, .rst_ni, .valid_i(start_i), .num_i({4'd0, clock_q}), .den_i(den3),
    .tag_i(baud_eff), .valid_o(va3), .quo_o(qa3), .tag_o(ta3));
  logic           vs;
  logic [ScW-1:0] qs;
  logic [0:0]     ts;
  bde_divpipe #(.NumW(ScW), .DenW(27), .TagW(1)) u_scale (
    .clk_i, .rst_ni, .valid_i(start_i), .num_i({clock_q, 4'd0}), .den_i(den1),
    .tag_i(1'b0), .valid_o(vs), .quo_o(qs), .tag_o(ts));

  // stage A: classify, register
  logic           vA_q;
  logic [1:0]     codeA_q;
  logic           specA_q;
  logic [26:0]    bestA_q, baudA_q;
  logic [ScW-1:0] scA_q;
  logic [26:0]    baud_a;
  assign baud_a = ta1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vA_q <= 1'b0;
    else vA_q <= va1;
  end
  always_ff @(posedge clk_i) begin
    baudA_q <= baud_a;
    scA_q   <= qs;
    if ({4'd0, baud_a} >= qa1) begin
      codeA_q <= bde_pkg::CodeFull;  bestA_q <= qa1[26:0]; specA_q <= 1'b1;
    end else if ({4'd0, baud_a} >= qa2) begin
      codeA_q <= bde_pkg::CodeOneHf; bestA_q <= qa2[26:0]; specA_q <= 1'b1;
    end else if ({4'd0, baud_a} >= qa3) begin
      codeA_q <= bde_pkg::CodeTwo;   bestA_q <= qa3[26:0]; specA_q <= 1'b1;
    end else begin
      codeA_q <= bde_pkg::CodeFull;  bestA_q <= '0; specA_q <= 1'b0;
    end
  end

  // divider b: half = scaled / baud
  localparam int unsigned TagB = 1 + 2 + 27 + ScW;
  logic            vb;
  logic [ScW-1:0]  qb;
  logic [TagB-1:0] tb;
  bde_divpipe #(.NumW(ScW), .DenW(27), .TagW(TagB)) u_half (
    .clk_i, .rst_ni, .valid_i(vA_q), .num_i(scA_q), .den_i(baudA_q),
    .tag_i({specA_q, codeA_q, bestA_q, scA_q}), .valid_o(vb), .quo_o(qb), .tag_o(tb));

  // stage B: round and clamp divisor
  logic            vB_q;
  logic [TagB-1:0] tB_q;
  logic [17:0]     divB_q;
  logic [ScW-1:0]  div_r;
  logic [17:0]     div_c;
  always_comb begin
    div_r = ScW'({1'b0, qb[ScW-1:1]} + {{(ScW-1){1'b0}}, qb[0]});
    if (div_r > ScW'(bde_pkg::DivLimit)) div_c = bde_pkg::DivClampVal;
    else div_c = div_r[17:0];
    if (div_c == '0) div_c = 18'd1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vB_q <= 1'b0;
    else vB_q <= vb;
  end
  always_ff @(posedge clk_i) begin
    tB_q   <= tb;
    divB_q <= div_c;
  end

  // divider c: twice = scaled / div
  localparam int unsigned TagC = 1 + 2 + 27 + 18;
  logic            vc;
  logic [ScW-1:0]  qc;
  logic [TagC-1:0] tc;
  bde_divpipe #(.NumW(ScW), .DenW(27), .TagW(TagC)) u_twice (
    .clk_i, .rst_ni, .valid_i(vB_q), .num_i(tB_q[ScW-1:0]),
    .den_i({9'd0, divB_q}),
    .tag_i({tB_q[TagB-1 -: 30], divB_q}), .valid_o(vc), .quo_o(qc), .tag_o(tc));

  // stage C: output register
  logic        done_q;
  logic [26:0] best_q;
  logic [16:0] enc_q;
  logic [17:0] div_o;
  logic [ScW-1:0] twice_r;
  assign div_o   = tc[17:0];
  assign twice_r = ScW'({1'b0, qc[ScW-1:1]} + {{(ScW-1){1'b0}}, qc[0]});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= vc;
  end
  // a divisor of exactly 0x20000 carries its integer part into bit 14
  always_ff @(posedge clk_i) begin
    if (tc[TagC-1]) begin
      best_q <= tc[44:18];
      enc_q  <= {15'd0, tc[46:45]};
    end else begin
      best_q <= twice_r[26:0];
      enc_q  <= {2'd0, div_o[17:3]} | {bde_pkg::frac_remap(div_o[2:0]), 14'd0};
    end
  end

  assign done_o            = done_q;
  assign best_baud_o       = best_q;
  assign encoded_divisor_o = enc_q;

  logic unused;
  assign unused = ^{ta2, ta3, ts, vs, va2, va3, twice_r[ScW-1:27]};

`ifndef SYNTHESIS
  a_vb: assert property (@(posedge clk_i) disable iff (!rst_ni) vB_q |-> divB_q != '0)
    else $error("zero divisor");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vB_q |-> divB_q <= bde_pkg::DivLimit) else $error("divisor over limit");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc |=> done_o) else $error("lost beat");
`endif

endmodule

[sim/baud_divisor_encoder_unit_tb.sv]
`timescale 1ns / 1ps

module baud_divisor_encoder_unit_tb;

  // rate checker: keeps its own copy of the clock and prescale settings,
  // predicts best rate and encoded divisor for each accepted request beat
  class baud_rate_board;
    longint unsigned clk_hz;
    longint unsigned pre;
    bit [26:0] baud_q[$];
    bit [16:0] code_q[$];
    int unsigned mismatches;
    bit [2:0] remap_tab[8];

    function new();
      clk_hz = bde_pkg::ClockReset;
      pre = bde_pkg::PrescaleReset;
      mismatches = 0;
      remap_tab = '{3'd0, 3'd3, 3'd2, 3'd4, 3'd1, 3'd5, 3'd6, 3'd7};
    endfunction

    function void set_reg(logic idx, logic [26:0] val);
      if (idx == bde_pkg::CfgIdxClock) clk_hz = val;
      else pre = val[4:0];
    endfunction

    function void note_request(logic [26:0] req);
      longint unsigned bd, p, best, enc, sc, half, dv, tw;
      p = (pre == 0) ? 1 : pre;
      bd = (req == 0) ? 1 : req;
      if (bd >= clk_hz / p) begin
        enc = bde_pkg::CodeFull;
        best = clk_hz / p;
      end else if (bd >= clk_hz / (p + p / 2)) begin
        enc = bde_pkg::CodeOneHf;
        best = clk_hz / (p + p / 2);
      end else if (bd >= clk_hz / (2 * p)) begin
        enc = bde_pkg::CodeTwo;
        best = clk_hz / (2 * p);
      end else begin
        sc = clk_hz * 16 / p;
        half = sc / bd;
        dv = (half >> 1) + (half & 1);
        if (dv > bde_pkg::DivLimit) dv = bde_pkg::DivClampVal;
        if (dv == 0) dv = 1;
        tw = sc / dv;
        best = (tw >> 1) + (tw & 1);
        enc = (dv >> 3) | (longint'(remap_tab[dv & 7]) << 14);
      end
      baud_q.push_back(best[26:0]);
      code_q.push_back(enc[16:0]);
    endfunction

    function void check_result(logic [26:0] best, logic [16:0] code);
      bit [26:0] eb;
      bit [16:0] ec;
      if (baud_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d %h", best, code);
        return;
      end
      eb = baud_q.pop_front();
      ec = code_q.pop_front();
      if (best !== eb || code !== ec) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: best exp %0d got %0d, code exp %h got %h", eb, best, ec, code);
      end
    endfunction

    function int pending();
      return baud_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [26:0] baud_req;
  logic        cfg_we;
  logic        cfg_idx;
  logic [26:0] cfg_data;
  logic        done;
  logic [26:0] rate_out;
  logic [16:0] enc_div;

  baud_rate_board board;
  int unsigned    quiet_cycles;
  bit             calm;          // no idling in the last part of the run
  longint unsigned cur_clk, cur_pre;

  localparam int unsigned DrainWait = 3 * 31 + 3 + 12;
  localparam int unsigned QuietLimit = 4000;

  baud_divisor_encoder_unit uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .baud_request_i   (baud_req),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .done_o           (done),
    .best_baud_o      (rate_out),
    .encoded_divisor_o(enc_div)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sample both sides at the rising edge; results cannot be held off
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_request(baud_req);
      if (done) board.check_result(rate_out, enc_div);
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on cycles where no beat moves on either side
  always @(posedge clk) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one request beat; holds start until the beat is taken
  task automatic send_request(logic [26:0] v);
    bit was_busy;
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    baud_req <= v;
    forever begin
      was_busy = busy;
      @(posedge clk);
      @(negedge clk);
      if (!was_busy) break;
    end
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (board.pending() != 0) @(negedge clk);
  endtask

  // register write only while nothing is in flight
  task automatic write_reg(logic idx, logic [26:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    if (idx == bde_pkg::CfgIdxClock) cur_clk = val;
    else cur_pre = val[4:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly log-spread rates, some near the code thresholds, some raw
  function automatic logic [26:0] pick_rate();
    longint unsigned p, t;
    int unsigned sel, sh;
    p = (cur_pre == 0) ? 1 : cur_pre;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      case ($urandom_range(0, 2))
        0: t = cur_clk / p;
        1: t = cur_clk / (p + p / 2);
        default: t = cur_clk / (2 * p);
      endcase
      t = t + $urandom_range(0, 2);
      t = (t == 0) ? 0 : t - 1;
      return t[26:0];
    end else if (sel == 2) begin
      return 27'($urandom);
    end
    sh = $urandom_range(0, 26);
    return 27'($urandom & ((32'd1 << (sh + 1)) - 1));
  endfunction

  task automatic random_block(int unsigned n, bit hold_once);
    for (int unsigned i = 0; i < n; i++) begin
      if (hold_once && i == n / 2) drain();
      send_request(pick_rate());
    end
  endtask

  initial begin
    longint unsigned p;
    board = new();
    rst_n = 1'b0;
    start = 1'b0;
    baud_req = '0;
    cfg_we = 1'b0;
    cfg_idx = bde_pkg::CfgIdxClock;
    cfg_data = '0;
    quiet_cycles = 0;
    calm = 1'b0;
    cur_clk = bde_pkg::ClockReset;
    cur_pre = bde_pkg::PrescaleReset;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: field extremes and the three code boundaries
    p = cur_pre;
    send_request(27'd0);
    send_request(27'd1);
    send_request(27'h7ffffff);
    send_request(27'(cur_clk / p));
    send_request(27'(cur_clk / p - 1));
    send_request(27'(cur_clk / (p + p / 2)));
    send_request(27'(cur_clk / (p + p / 2) - 1));
    send_request(27'(cur_clk / (2 * p)));
    send_request(27'(cur_clk / (2 * p) - 1));
    random_block(200, 1'b1);

    // lowest clock, lowest prescale
    drain();
    write_reg(bde_pkg::CfgIdxClock, 27'd1000000);
    write_reg(bde_pkg::CfgIdxPrescale, 27'd2);
    random_block(220, 1'b0);

    // highest clock, highest prescale
    drain();
    write_reg(bde_pkg::CfgIdxClock, 27'd120000000);
    write_reg(bde_pkg::CfgIdxPrescale, 27'd16);
    random_block(220, 1'b0);

    // highest clock, lowest prescale
    drain();
    write_reg(bde_pkg::CfgIdxPrescale, 27'd2);
    random_block(220, 1'b0);

    // divisor lands exactly on the limit at rate 1, clamps below that
    drain();
    write_reg(bde_pkg::CfgIdxClock, 27'd262144);
    write_reg(bde_pkg::CfgIdxPrescale, 27'd16);
    send_request(27'd1);
    send_request(27'd0);
    random_block(100, 1'b0);
    drain();
    write_reg(bde_pkg::CfgIdxClock, 27'd263000);
    send_request(27'd1);

    // zero clock and zero prescale
    drain();
    write_reg(bde_pkg::CfgIdxClock, 27'd0);
    write_reg(bde_pkg::CfgIdxPrescale, 27'd0);
    send_request(27'd5);
    send_request(27'h7ffffff);
    drain();
    write_reg(bde_pkg::CfgIdxClock, 27'd48000000);
    random_block(100, 1'b0);

    // random settings, odd prescales too, last stretch with no idling
    for (int unsigned k = 0; k < 3; k++) begin
      drain();
      write_reg(bde_pkg::CfgIdxClock, 27'($urandom_range(1000000, 120000000)));
      write_reg(bde_pkg::CfgIdxPrescale, 27'($urandom_range(2, 16)));
      if (k == 2) calm = 1'b1;
      random_block(160, 1'b0);
    end

    drain();
    repeat (DrainWait) @(negedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
